### rtl/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time block.
package mbe_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 16;
    localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic at_limit;
        logic escape;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/mbe_ctrl.sv
// Sequencer for the escape-time iteration: load, multiply, evaluate, hand off.
module mbe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mbe_pkg::dp_status_t status,
    output mbe_pkg::dp_cmd_t    cmd
);
    import mbe_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done;

    assign done = status.at_limit || status.escape;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (!done) begin
                    state_next = ST_MUL;
                end else if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // no item is taken while reset is held
    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_EVAL: begin
                cmd.step   = !done;
                cmd.finish = done && status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/mbe_datapath.sv
// Datapath: z registers, product stage, escape test, update and result register.
module mbe_datapath #(
    parameter int FRAC_BITS = 28
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mbe_pkg::dp_cmd_t                  cmd,
    output mbe_pkg::dp_status_t               status,
    input  logic                              cfg_wr_en,
    input  logic        [mbe_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic signed [mbe_pkg::WORD_W-1:0] s_c_real,
    input  logic signed [mbe_pkg::WORD_W-1:0] s_c_imag,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic        [mbe_pkg::CNT_W-1:0]  m_escape_count,
    output logic                              m_in_set
);
    import mbe_pkg::*;

    localparam int PROD_W = 2 * WORD_W;
    localparam logic [PROD_W-1:0] ESC_LIMIT = 64'd4 << FRAC_BITS;
    localparam logic [PROD_W-1:0] SQ_MAX    = 64'h0000_0000_7FFF_FFFF;

    logic signed [WORD_W-1:0] c_re_reg, c_im_reg;
    logic signed [WORD_W-1:0] zr_reg, zr_next;
    logic signed [WORD_W-1:0] zi_reg, zi_next;
    logic        [CNT_W-1:0]  k_reg;
    logic        [CNT_W-1:0]  max_iter_reg;
    logic        [PROD_W-1:0] sq_r_prod_reg, sq_i_prod_reg;
    logic signed [PROD_W-1:0] cross_reg;
    logic                     m_valid_reg;
    logic        [CNT_W-1:0]  escape_count_reg;
    logic                     in_set_reg;

    logic signed [PROD_W-1:0] mul_rr, mul_ii, mul_ri;
    logic        [PROD_W-1:0] sq_r_full, sq_i_full;
    logic        [WORD_W-2:0] sq_r, sq_i;
    logic        [WORD_W-1:0] mag;
    logic        [WORD_W+1:0] re_sum;
    logic signed [PROD_W-1:0] cross_sh;
    logic        [PROD_W:0]   im_sum;

    // product stage: signed 32x32 products, operands sign-extended
    always_comb begin
        mul_rr = PROD_W'(zr_reg) * PROD_W'(zr_reg);
        mul_ii = PROD_W'(zi_reg) * PROD_W'(zi_reg);
        mul_ri = PROD_W'(zr_reg) * PROD_W'(zi_reg);
    end

    // evaluate stage
    always_comb begin
        sq_r_full = sq_r_prod_reg >> FRAC_BITS;
        sq_i_full = sq_i_prod_reg >> FRAC_BITS;
        sq_r      = (sq_r_full > SQ_MAX) ? SQ_MAX[WORD_W-2:0] : sq_r_full[WORD_W-2:0];
        sq_i      = (sq_i_full > SQ_MAX) ? SQ_MAX[WORD_W-2:0] : sq_i_full[WORD_W-2:0];
        mag       = {1'b0, sq_r} + {1'b0, sq_i};

        re_sum = {3'b000, sq_r} - {3'b000, sq_i} + {{2{c_re_reg[WORD_W-1]}}, c_re_reg};
        if (re_sum[WORD_W+1:WORD_W-1] == 3'b000 || re_sum[WORD_W+1:WORD_W-1] == 3'b111) begin
            zr_next = re_sum[WORD_W-1:0];
        end else if (re_sum[WORD_W+1]) begin
            zr_next = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            zr_next = {1'b0, {(WORD_W-1){1'b1}}};
        end

        cross_sh = cross_reg >>> (FRAC_BITS - 1);
        im_sum   = {cross_sh[PROD_W-1], cross_sh}
                 + {{(PROD_W-WORD_W+1){c_im_reg[WORD_W-1]}}, c_im_reg};
        if (im_sum[PROD_W:WORD_W-1] == '0 || im_sum[PROD_W:WORD_W-1] == '1) begin
            zi_next = im_sum[WORD_W-1:0];
        end else if (im_sum[PROD_W]) begin
            zi_next = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            zi_next = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    assign status.at_limit = (k_reg == max_iter_reg);
    assign status.escape   = ({{(PROD_W-WORD_W){1'b0}}, mag} > ESC_LIMIT);
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_iter_reg <= cfg_wr_data;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            c_re_reg <= s_c_real;
            c_im_reg <= s_c_imag;
            zr_reg   <= '0;
            zi_reg   <= '0;
            k_reg    <= '0;
        end else if (cmd.step) begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
            k_reg  <= k_reg + 1'b1;
        end
        if (cmd.mul) begin
            sq_r_prod_reg <= mul_rr;
            sq_i_prod_reg <= mul_ii;
            cross_reg     <= mul_ri;
        end
        if (cmd.finish) begin
            escape_count_reg <= status.at_limit ? '0 : k_reg;
            in_set_reg       <= status.at_limit;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_escape_count = escape_count_reg;
    assign m_in_set       = in_set_reg;

endmodule

### rtl/mandelbrot_escape_time.sv
// Mandelbrot escape-time unit: top level joining sequencer and datapath.
//
// Input channel (s_valid/s_ready, s_c_real, s_c_imag): one point c per item,
// signed fixed point with FRAC_BITS fraction bits.
// Result channel (m_valid/m_ready, m_escape_count, m_in_set): one item per
// point; the step at which |z|^2 first exceeded 4, or in_set with count 0.
// cfg_wr_en/cfg_wr_data write the iteration limit (reset value 256); write
// only while no point is in flight.
// Each step runs the multiply state, which registers the three 32x32
// products, then the evaluate state, for the escape test and the z update. A
// point steps until it escapes or its step count reaches the limit; its
// result is registered as it finishes, and only then is a new point taken.
// The result register is separate, so the next point is taken and iterated
// while a result waits; a finished point holds in the evaluate step until
// that register frees. Reset empties the result register and restores the
// limit.
module mandelbrot_escape_time #(
    parameter int FRAC_BITS = 28
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic        [mbe_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [mbe_pkg::WORD_W-1:0] s_c_real,
    input  logic signed [mbe_pkg::WORD_W-1:0] s_c_imag,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic        [mbe_pkg::CNT_W-1:0]  m_escape_count,
    output logic                              m_in_set
);
    import mbe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mbe_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_c_real       (s_c_real),
        .s_c_imag       (s_c_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .m_in_set       (m_in_set)
    );

endmodule
